>>> design/aelex_pkg.sv
// Shared types, constants and helpers for the arithmetic expression lexer.
package aelex_pkg;

    localparam int PosW  = 16;
    localparam int IdxW  = 24;
    localparam int ValW  = 64;
    localparam int Slots = 3;
    localparam int QDepth = 2;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    localparam logic [PosW-1:0] PosMax = '1;
    localparam logic [IdxW-1:0] IdxMax = '1;
    localparam logic [PosW-1:0] PosOne = PosW'(1);

    // token slot order within one transaction
    localparam int SlotNum = 0;
    localparam int SlotOp  = 1;
    localparam int SlotEnd = 2;

    localparam logic [7:0] CharZero   = 8'h30;
    localparam logic [7:0] CharNine   = 8'h39;
    localparam logic [7:0] CharNl     = 8'h0a;
    localparam logic [7:0] CharTab    = 8'h09;
    localparam logic [7:0] CharCr     = 8'h0d;
    localparam logic [7:0] CharSpace  = 8'h20;
    localparam logic [7:0] CharLparen = 8'h28;
    localparam logic [7:0] CharRparen = 8'h29;
    localparam logic [7:0] CharPlus   = 8'h2b;
    localparam logic [7:0] CharMinus  = 8'h2d;
    localparam logic [7:0] CharStar   = 8'h2a;
    localparam logic [7:0] CharSlash  = 8'h2f;

    typedef enum logic [3:0] {
        KIND_END     = 4'd0,
        KIND_NUMBER  = 4'd1,
        KIND_LPAREN  = 4'd2,
        KIND_RPAREN  = 4'd3,
        KIND_PLUS    = 4'd4,
        KIND_MINUS   = 4'd5,
        KIND_STAR    = 4'd6,
        KIND_SLASH   = 4'd7,
        KIND_INVALID = 4'd8
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [ValW-1:0]  value;
        logic [PosW-1:0]  line;
        logic [PosW-1:0]  col;
        logic [IdxW-1:0]  idx;
        logic [7:0]       bad;
    } token_t;

    typedef struct packed {
        logic [Slots-1:0]   valid;
        token_t [Slots-1:0] tok;
    } entry_t;

    function automatic logic [PosW-1:0] pos_inc(input logic [PosW-1:0] v);
        pos_inc = (v == PosMax) ? PosMax : v + PosOne;
    endfunction

    function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] v);
        idx_inc = (v == IdxMax) ? IdxMax : v + IdxW'(1);
    endfunction

endpackage

>>> design/aelex_front.sv
// Front end: accepts text bytes, tracks position and numbers, builds token transactions.
module aelex_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_ch,
    input  logic                  s_char_present,
    input  logic                  s_end_of_text,
    input  logic                  q_full,
    output logic                  push,
    output aelex_pkg::entry_t     push_entry
);
    import aelex_pkg::*;

    logic            in_num_reg, in_num_next;
    logic [ValW-1:0] acc_reg, acc_next;
    logic [PosW-1:0] start_col_reg, start_col_next;
    logic [IdxW-1:0] start_idx_reg, start_idx_next;
    logic [PosW-1:0] line_reg, line_next;
    logic [PosW-1:0] col_reg, col_next;
    logic [IdxW-1:0] idx_reg, idx_next;

    logic            accept;
    logic            digit, is_op, is_ws, is_nl, close_num;
    kind_t           op_kind;
    logic [ValW-1:0] acc_base, acc_mul;
    logic            in_num_b;
    logic [ValW-1:0] acc_b;
    logic [PosW-1:0] start_col_b, line_b, col_b;
    logic [IdxW-1:0] start_idx_b, idx_b;
    entry_t          ent;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        digit = s_ch inside {[CharZero:CharNine]};
        is_nl = (s_ch == CharNl);
        is_ws = (s_ch == CharSpace) || (s_ch inside {[CharTab:CharCr]});
        is_op = 1'b1;
        case (s_ch)
            CharLparen: op_kind = KIND_LPAREN;
            CharRparen: op_kind = KIND_RPAREN;
            CharPlus:   op_kind = KIND_PLUS;
            CharMinus:  op_kind = KIND_MINUS;
            CharStar:   op_kind = KIND_STAR;
            CharSlash:  op_kind = KIND_SLASH;
            default: begin
                op_kind = KIND_INVALID;
                is_op   = 1'b0;
            end
        endcase
    end

    // value * 10 + digit, wrapping
    assign acc_base = in_num_reg ? acc_reg : '0;
    assign acc_mul  = {acc_base[ValW-4:0], 3'b000} + {acc_base[ValW-2:0], 1'b0}
                    + ValW'(s_ch - CharZero);

    always_comb begin
        close_num   = s_char_present && in_num_reg && !digit;
        in_num_b    = in_num_reg;
        acc_b       = acc_reg;
        start_col_b = start_col_reg;
        start_idx_b = start_idx_reg;
        line_b      = line_reg;
        col_b       = col_reg;
        idx_b       = idx_reg;

        ent = '0;
        ent.tok[SlotNum].kind = KIND_NUMBER;
        ent.tok[SlotNum].value = acc_reg;
        ent.tok[SlotNum].line = line_reg;
        ent.tok[SlotNum].col = start_col_reg;
        ent.tok[SlotNum].idx = start_idx_reg;
        ent.tok[SlotOp].kind = op_kind;
        ent.tok[SlotOp].line = line_reg;
        ent.tok[SlotOp].col = col_reg;
        ent.tok[SlotOp].idx = idx_reg;
        ent.tok[SlotOp].bad = is_op ? 8'h00 : s_ch;
        ent.tok[SlotEnd].kind = KIND_END;

        if (s_char_present) begin
            ent.valid[SlotNum] = close_num;
            in_num_b = digit;
            if (digit) begin
                if (!in_num_reg) begin
                    start_col_b = col_reg;
                    start_idx_b = idx_reg;
                end
                acc_b = acc_mul;
                col_b = pos_inc(col_reg);
                idx_b = idx_inc(idx_reg);
            end else if (is_nl) begin
                acc_b  = '0;
                line_b = pos_inc(line_reg);
                col_b  = PosOne;
                idx_b  = idx_inc(idx_reg);
            end else begin
                acc_b = '0;
                ent.valid[SlotOp] = !is_ws;
                col_b = pos_inc(col_reg);
                idx_b = idx_inc(idx_reg);
            end
        end

        if (s_end_of_text) begin
            // a byte that closed the number leaves in_num_b low, so one number slot suffices
            if (in_num_b) begin
                ent.valid[SlotNum]     = 1'b1;
                ent.tok[SlotNum].value = acc_b;
                ent.tok[SlotNum].col   = start_col_b;
                ent.tok[SlotNum].idx   = start_idx_b;
            end
            ent.valid[SlotEnd]    = 1'b1;
            ent.tok[SlotEnd].line = line_b;
            ent.tok[SlotEnd].col  = col_b;
            ent.tok[SlotEnd].idx  = idx_b;
        end

        if (!ent.valid[SlotNum]) begin
            ent.tok[SlotNum].value = '0;
        end

        in_num_next    = in_num_reg;
        acc_next       = acc_reg;
        start_col_next = start_col_reg;
        start_idx_next = start_idx_reg;
        line_next      = line_reg;
        col_next       = col_reg;
        idx_next       = idx_reg;
        if (accept) begin
            if (s_end_of_text) begin
                in_num_next    = 1'b0;
                acc_next       = '0;
                start_col_next = PosOne;
                start_idx_next = '0;
                line_next      = PosOne;
                col_next       = PosOne;
                idx_next       = '0;
            end else begin
                in_num_next    = in_num_b;
                acc_next       = acc_b;
                start_col_next = start_col_b;
                start_idx_next = start_idx_b;
                line_next      = line_b;
                col_next       = col_b;
                idx_next       = idx_b;
            end
        end
    end

    assign push       = accept && (ent.valid != '0);
    assign push_entry = ent;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_num_reg    <= 1'b0;
            acc_reg       <= '0;
            start_col_reg <= PosOne;
            start_idx_reg <= '0;
            line_reg      <= PosOne;
            col_reg       <= PosOne;
            idx_reg       <= '0;
        end else begin
            in_num_reg    <= in_num_next;
            acc_reg       <= acc_next;
            start_col_reg <= start_col_next;
            start_idx_reg <= start_idx_next;
            line_reg      <= line_next;
            col_reg       <= col_next;
            idx_reg       <= idx_next;
        end
    end

endmodule

>>> design/aelex_queue.sv
// Two-entry queue of token transactions between front and back.
module aelex_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  aelex_pkg::entry_t  push_entry,
    input  logic               pop,
    output logic               full,
    output logic               head_valid,
    output aelex_pkg::entry_t  head
);
    import aelex_pkg::*;

    entry_t           mem [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCntW-1:0] count_reg, count_next;

    assign full       = (count_reg == QCntW'(QDepth));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPtrW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPtrW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCntW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("queue pop while empty");
    a_entry_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (push_entry.valid != '0))
        else $error("empty transaction pushed");
`endif

endmodule

>>> design/aelex_back.sv
// Back end: unrolls each queued transaction into tokens on the output register.
module aelex_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          head_valid,
    input  aelex_pkg::entry_t             head,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [3:0]                    m_kind,
    output logic [aelex_pkg::ValW-1:0]    m_number_value,
    output logic [aelex_pkg::PosW-1:0]    m_line_no,
    output logic [aelex_pkg::PosW-1:0]    m_column_no,
    output logic [aelex_pkg::IdxW-1:0]    m_byte_index,
    output logic [7:0]                    m_bad_byte,
    output logic                          m_last_of_run
);
    import aelex_pkg::*;

    logic [Slots-1:0] done_reg, done_next;
    logic [Slots-1:0] remaining, pick, rest;
    logic             load, last;
    logic             m_valid_reg, m_valid_next;
    logic             last_reg;
    token_t           tok_reg, sel;

    always_comb begin
        remaining = head.valid & ~done_reg;
        pick = '0;
        sel  = head.tok[SlotEnd];
        if (remaining[SlotNum]) begin
            pick[SlotNum] = 1'b1;
            sel = head.tok[SlotNum];
        end else if (remaining[SlotOp]) begin
            pick[SlotOp] = 1'b1;
            sel = head.tok[SlotOp];
        end else begin
            pick[SlotEnd] = 1'b1;
        end
        rest = remaining & ~pick;
        last = (rest == '0);
        load = head_valid && (!m_valid_reg || m_ready);
        pop  = load && last;

        done_next    = done_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            done_next    = last ? '0 : (done_reg | pick);
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tok_reg  <= sel;
            last_reg <= last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = tok_reg.kind;
    assign m_number_value = tok_reg.value;
    assign m_line_no      = tok_reg.line;
    assign m_column_no    = tok_reg.col;
    assign m_byte_index   = tok_reg.idx;
    assign m_bad_byte     = tok_reg.bad;
    assign m_last_of_run  = last_reg;

`ifndef SYNTHESIS
    a_head_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> ((head.valid & ~done_reg) != '0))
        else $error("head transaction has no token left");
    a_idle_done_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !head_valid |-> (done_reg == '0))
        else $error("progress mask set with empty queue");
    a_pop_marks_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (m_valid && m_last_of_run))
        else $error("pop without last token shown");
`endif

endmodule

>>> design/arithmetic_expression_lexer.sv
// Top level of the streaming arithmetic expression lexer.
//
// Input channel (s_*): one text byte per transaction in s_ch when
// s_char_present is high; s_end_of_text closes the text after that byte.
// Output channel (m_*): one token per transaction with its kind, number
// value, start line, column and byte index, the offending byte of an
// invalid token, and m_last_of_run on the final token of an input item.
// An input item yields zero to three tokens.
// When the queue holds nothing older and the output is free, an accepted item
// is written into the queue and its first token then loaded into the output
// register, raising m_valid. One input byte per cycle while the two-entry
// transaction queue has room; the output register drains one token per cycle
// while m_ready is high, and an item with several tokens holds the queue head.
// Reset (aresetn low, synchronous): position returns to line 1, column 1,
// index 0, the queue and output empty. When m_ready is low the output holds,
// the queue fills, and s_ready drops once both queue entries are taken.
module arithmetic_expression_lexer (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_ch,
    input  logic                       s_char_present,
    input  logic                       s_end_of_text,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [3:0]                 m_kind,
    output logic [aelex_pkg::ValW-1:0] m_number_value,
    output logic [aelex_pkg::PosW-1:0] m_line_no,
    output logic [aelex_pkg::PosW-1:0] m_column_no,
    output logic [aelex_pkg::IdxW-1:0] m_byte_index,
    output logic [7:0]                 m_bad_byte,
    output logic                       m_last_of_run
);
    import aelex_pkg::*;

    logic   q_full, push, pop, head_valid;
    entry_t push_entry, head;

    aelex_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_ch           (s_ch),
        .s_char_present (s_char_present),
        .s_end_of_text  (s_end_of_text),
        .q_full         (q_full),
        .push           (push),
        .push_entry     (push_entry)
    );

    aelex_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    aelex_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_valid     (head_valid),
        .head           (head),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_number_value (m_number_value),
        .m_line_no      (m_line_no),
        .m_column_no    (m_column_no),
        .m_byte_index   (m_byte_index),
        .m_bad_byte     (m_bad_byte),
        .m_last_of_run  (m_last_of_run)
    );

endmodule

>>> tb/arithmetic_expression_lexer_tb.sv
// Testbench for the arithmetic expression lexer: random and directed text, token scoreboard.
module arithmetic_expression_lexer_tb;
    import aelex_pkg::*;

    localparam logic [7:0] CharVt = 8'h0b;
    localparam logic [7:0] CharFf = 8'h0c;

    typedef struct packed {
        logic [7:0] ch;
        logic       present;
        logic       eot;
    } text_item_t;

    typedef struct packed {
        kind_t           kind;
        logic [ValW-1:0] value;
        logic [PosW-1:0] line;
        logic [PosW-1:0] col;
        logic [IdxW-1:0] idx;
        logic [7:0]      bad;
        logic            last;
    } lex_token_t;

    logic            aclk;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    logic [7:0]      s_ch = 8'h00;
    logic            s_char_present = 1'b0;
    logic            s_end_of_text = 1'b0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    logic [3:0]      m_kind;
    logic [ValW-1:0] m_number_value;
    logic [PosW-1:0] m_line_no;
    logic [PosW-1:0] m_column_no;
    logic [IdxW-1:0] m_byte_index;
    logic [7:0]      m_bad_byte;
    logic            m_last_of_run;

    text_item_t pending_text[$];
    lex_token_t tokens_due[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;

    // predicted lexer state
    logic            lex_in_num;
    logic [ValW-1:0] lex_acc;
    logic [PosW-1:0] lex_num_col;
    logic [IdxW-1:0] lex_num_idx;
    logic [PosW-1:0] lex_line;
    logic [PosW-1:0] lex_col;
    logic [IdxW-1:0] lex_idx;

    arithmetic_expression_lexer uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_ch(s_ch),
        .s_char_present(s_char_present),
        .s_end_of_text(s_end_of_text),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_kind(m_kind),
        .m_number_value(m_number_value),
        .m_line_no(m_line_no),
        .m_column_no(m_column_no),
        .m_byte_index(m_byte_index),
        .m_bad_byte(m_bad_byte),
        .m_last_of_run(m_last_of_run)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [PosW-1:0] pos_bump(input logic [PosW-1:0] v);
        return (v == {PosW{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic logic [IdxW-1:0] idx_bump(input logic [IdxW-1:0] v);
        return (v == {IdxW{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic lex_token_t make_token(input kind_t k, input logic [ValW-1:0] v,
                                              input logic [PosW-1:0] ln,
                                              input logic [PosW-1:0] cl,
                                              input logic [IdxW-1:0] ix,
                                              input logic [7:0] b);
        lex_token_t t;
        t.kind = k;
        t.value = v;
        t.line = ln;
        t.col = cl;
        t.idx = ix;
        t.bad = b;
        t.last = 1'b0;
        return t;
    endfunction

    task automatic clear_lexer();
        lex_in_num = 1'b0;
        lex_acc = '0;
        lex_num_col = PosOne;
        lex_num_idx = '0;
        lex_line = PosOne;
        lex_col = PosOne;
        lex_idx = '0;
    endtask

    // tokens caused by one accepted text item
    task automatic lex_step(input logic [7:0] c, input logic present, input logic eot);
        lex_token_t found[3];
        int n;
        logic digit;
        logic is_op;
        kind_t opk;
        n = 0;
        opk = KIND_END;
        if (present) begin
            digit = (c >= CharZero) && (c <= CharNine);
            is_op = 1'b1;
            case (c)
                CharLparen: opk = KIND_LPAREN;
                CharRparen: opk = KIND_RPAREN;
                CharPlus:   opk = KIND_PLUS;
                CharMinus:  opk = KIND_MINUS;
                CharStar:   opk = KIND_STAR;
                CharSlash:  opk = KIND_SLASH;
                default:    is_op = 1'b0;
            endcase
            if (lex_in_num && !digit) begin
                found[n] = make_token(KIND_NUMBER, lex_acc, lex_line, lex_num_col,
                                      lex_num_idx, 8'h00);
                n++;
                lex_in_num = 1'b0;
                lex_acc = '0;
            end
            if (digit) begin
                if (!lex_in_num) begin
                    lex_in_num = 1'b1;
                    lex_acc = '0;
                    lex_num_col = lex_col;
                    lex_num_idx = lex_idx;
                end
                lex_acc = lex_acc * 64'd10 + ValW'(c) - ValW'(CharZero);
                lex_col = pos_bump(lex_col);
                lex_idx = idx_bump(lex_idx);
            end else if (is_op) begin
                found[n] = make_token(opk, '0, lex_line, lex_col, lex_idx, 8'h00);
                n++;
                lex_col = pos_bump(lex_col);
                lex_idx = idx_bump(lex_idx);
            end else if (c == CharNl) begin
                lex_line = pos_bump(lex_line);
                lex_col = PosOne;
                lex_idx = idx_bump(lex_idx);
            end else if (c == CharSpace || (c >= CharTab && c <= CharCr)) begin
                lex_col = pos_bump(lex_col);
                lex_idx = idx_bump(lex_idx);
            end else begin
                found[n] = make_token(KIND_INVALID, '0, lex_line, lex_col, lex_idx, c);
                n++;
                lex_col = pos_bump(lex_col);
                lex_idx = idx_bump(lex_idx);
            end
        end
        if (eot) begin
            if (lex_in_num) begin
                found[n] = make_token(KIND_NUMBER, lex_acc, lex_line, lex_num_col,
                                      lex_num_idx, 8'h00);
                n++;
            end
            found[n] = make_token(KIND_END, '0, lex_line, lex_col, lex_idx, 8'h00);
            n++;
            clear_lexer();
        end
        for (int i = 0; i < n; i++) begin
            if (i == n - 1)
                found[i].last = 1'b1;
            tokens_due.push_back(found[i]);
        end
    endtask

    task automatic queue_item(input logic [7:0] c, input logic present, input logic eot);
        text_item_t it;
        it.ch = c;
        it.present = present;
        it.eot = eot;
        pending_text.push_back(it);
    endtask

    task automatic queue_byte(input logic [7:0] c);
        queue_item(c, 1'b1, 1'b0);
    endtask

    // mostly well-formed expression text with random content, plus noise
    task automatic queue_random_text(input int count);
        int made;
        int r;
        int len;
        logic [7:0] c;
        made = 0;
        while (made < count) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                len = ($urandom_range(0, 14) == 0) ? $urandom_range(18, 24)
                                                   : $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    queue_byte(CharZero + 8'($urandom_range(0, 9)));
                made += len;
            end else if (r < 60) begin
                case ($urandom_range(0, 5))
                    0: c = CharLparen;
                    1: c = CharRparen;
                    2: c = CharPlus;
                    3: c = CharMinus;
                    4: c = CharStar;
                    default: c = CharSlash;
                endcase
                queue_byte(c);
                made++;
            end else if (r < 75) begin
                case ($urandom_range(0, 5))
                    0: c = CharSpace;
                    1: c = CharTab;
                    2: c = CharNl;
                    3: c = CharVt;
                    4: c = CharFf;
                    default: c = CharCr;
                endcase
                queue_byte(c);
                made++;
            end else if (r < 81) begin
                queue_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
                made++;
            end else if (r < 85) begin
                queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end else begin
                queue_item(8'($urandom_range(0, 255)), 1'b1,
                           1'($urandom_range(0, 7) == 0));
                made++;
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge aclk);
        while (pending_text.size() != 0 || s_valid || tokens_due.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // driver
    always @(posedge aclk) begin : drive
        text_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_ch <= 8'h00;
            s_char_present <= 1'b0;
            s_end_of_text <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                lex_step(s_ch, s_char_present, s_end_of_text);
            if (!s_valid || s_ready) begin
                if (pending_text.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending_text.pop_front();
                    s_valid <= 1'b1;
                    s_ch <= nxt.ch;
                    s_char_present <= nxt.present;
                    s_end_of_text <= nxt.eot;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and scoreboard
    always @(posedge aclk) begin : watch
        lex_token_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (tokens_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected token: kind %0d value %0d line %0d col %0d idx %0d",
                                 m_kind, m_number_value, m_line_no, m_column_no,
                                 m_byte_index);
                end else begin
                    want = tokens_due.pop_front();
                    if (m_kind !== want.kind || m_number_value !== want.value ||
                        m_line_no !== want.line || m_column_no !== want.col ||
                        m_byte_index !== want.idx || m_bad_byte !== want.bad ||
                        m_last_of_run !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"token mismatch exp: kind %0d value %0d line %0d",
                                      " col %0d idx %0d bad %h last %0b"},
                                     want.kind, want.value, want.line, want.col, want.idx,
                                     want.bad, want.last);
                            $display({"               got: kind %0d value %0d line %0d",
                                      " col %0d idx %0d bad %h last %0b"},
                                     m_kind, m_number_value, m_line_no, m_column_no,
                                     m_byte_index, m_bad_byte, m_last_of_run);
                        end
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        clear_lexer();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: every token kind, byte extremes, whitespace, end handling
        queue_byte(CharLparen);
        queue_byte(CharZero);
        queue_byte(CharNine);
        queue_byte(CharRparen);
        queue_byte(CharPlus);
        queue_byte(CharMinus);
        queue_byte(CharStar);
        queue_byte(CharSlash);
        queue_byte(8'h00);
        queue_byte(8'hff);
        queue_byte(CharNl);
        queue_byte(CharSpace);
        queue_byte(CharTab);
        queue_byte(CharCr);
        queue_byte(CharVt);
        queue_byte(CharZero + 8'd7);
        queue_item(8'hff, 1'b0, 1'b0);
        queue_byte(CharZero + 8'd8);
        queue_item(CharPlus, 1'b1, 1'b1);
        queue_item(8'h00, 1'b0, 1'b1);
        queue_byte(CharZero + 8'd4);
        queue_item(8'h55, 1'b0, 1'b1);
        queue_item(CharZero + 8'd3, 1'b1, 1'b1);
        queue_random_text(82);
        wait_drained();

        send_idle_pct = 74;
        queue_random_text(82);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 74;
        queue_random_text(82);
        wait_drained();

        send_idle_pct = 18;
        recv_stall_pct = 18;
        queue_random_text(82);
        wait_drained();

        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
